>>> src/eac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package eac_pkg;

  // Block sizes
  localparam int MAX_LAG      = 288;
  localparam int SAMPLE_BITS  = 12;
  localparam int LAG_W        = 9;
  localparam int ENV_W        = 12;
  localparam int WIN_W        = 19;
  localparam int M_W          = 18;
  localparam int PROD_W       = 41;
  localparam int SUM_W        = 30;
  localparam int OUT_W        = 60;
  localparam int SQ_W         = 25;
  localparam int SQRT_STEPS   = 12;
  localparam int STEP_W       = 4;
  localparam int PLO_W        = 21;
  localparam int PHI_W        = PROD_W - PLO_W;

  localparam logic [LAG_W-1:0] LAG_TOP   = LAG_W'(MAX_LAG);
  localparam logic [LAG_W-1:0] HIST_LAST = LAG_W'(MAX_LAG - 1);
  localparam logic [WIN_W-1:0] WIN_MIN   = WIN_W'(MAX_LAG + 1);
  localparam logic [WIN_W-1:0] WIN_MAX   = WIN_W'(262144);
  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(65536);

  // Action codes
  localparam logic [1:0] ACT_SAMPLE  = 2'd0;
  localparam logic [1:0] ACT_READ    = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SQRT,
    ST_LAG,
    ST_DRAIN,
    ST_RD_ADDR,
    ST_RD_MUL,
    ST_RD_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic sqrt_start;
    logic lag_run;
    logic finish;
    logic clr_run;
    logic rd_mul;
    logic rd_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] action;
    logic       sample_ok;
    logic       sqrt_done;
    logic       lag_last;
    logic       clr_last;
    logic       out_free;
  } stat_t;

endpackage

`default_nettype wire

>>> src/eac_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module eac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/eac_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module eac_sqrt (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [eac_pkg::SQ_W-1:0]   x,
  output logic                            done,
  output logic      [eac_pkg::ENV_W-1:0]  root
);
  import eac_pkg::*;

  logic [SQ_W-1:0]   rem_r, rem_nxt;
  logic [SQ_W-1:0]   root_r, root_nxt;
  logic [STEP_W-1:0] k_r, k_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [SQ_W-1:0]   bitv;
  logic [SQ_W-1:0]   trial;

  // One result bit per cycle, restoring digit recurrence
  always_comb begin
    bitv     = SQ_W'(1) << {k_r, 1'b0};
    trial    = root_r + bitv;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    k_nxt    = k_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = x;
      root_nxt = '0;
      k_nxt    = STEP_W'(SQRT_STEPS - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_nxt  = rem_r - trial;
        root_nxt = (root_r >> 1) + bitv;
      end else begin
        root_nxt = root_r >> 1;
      end
      if (k_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        k_nxt = k_r - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    k_r    <= k_nxt;
  end

  assign done = done_r;
  assign root = root_r[ENV_W-1:0];

endmodule

`default_nettype wire

>>> src/eac_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module eac_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire eac_pkg::stat_t stat,
  output eac_pkg::cmd_t       cmd
);
  import eac_pkg::*;

  state_t state_r, state_nxt;
  logic   take;

  assign take = (state_r == ST_IDLE) && in_valid;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:   if (stat.clr_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (take) begin
          priority if (stat.action == ACT_SAMPLE && stat.sample_ok) state_nxt = ST_SQRT;
          else if (stat.action == ACT_READ)    state_nxt = ST_RD_ADDR;
          else if (stat.action == ACT_RESTART) state_nxt = ST_CLEAR;
          else                                 state_nxt = ST_IDLE;
        end
      end
      ST_SQRT:    if (stat.sqrt_done) state_nxt = ST_LAG;
      ST_LAG:     if (stat.lag_last) state_nxt = ST_DRAIN;
      ST_DRAIN:   state_nxt = ST_IDLE;
      ST_RD_ADDR: state_nxt = ST_RD_MUL;
      ST_RD_MUL:  state_nxt = ST_RD_OUT;
      ST_RD_OUT:  if (stat.out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd            = '0;
    in_stall       = (state_r != ST_IDLE);
    cmd.accept     = take;
    cmd.sqrt_start = take && (stat.action == ACT_SAMPLE) && stat.sample_ok;
    cmd.lag_run    = (state_r == ST_LAG);
    cmd.finish     = (state_r == ST_DRAIN);
    cmd.clr_run    = (state_r == ST_CLEAR);
    cmd.rd_mul     = (state_r == ST_RD_MUL);
    cmd.rd_load    = (state_r == ST_RD_OUT) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/eac_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module eac_dp (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire eac_pkg::cmd_t                      cmd,
  output eac_pkg::stat_t                          stat,
  input  wire logic [1:0]                         in_action,
  input  wire logic signed [eac_pkg::SAMPLE_BITS-1:0] in_in_phase,
  input  wire logic signed [eac_pkg::SAMPLE_BITS-1:0] in_quadrature,
  input  wire logic [eac_pkg::LAG_W-1:0]          in_read_lag,
  input  wire logic                               cfg_wr_en,
  input  wire logic [eac_pkg::WIN_W-1:0]          cfg_wr_data,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic      [eac_pkg::LAG_W-1:0]          out_lag,
  output logic signed [eac_pkg::OUT_W-1:0]        out_scaled_covariance,
  output logic                                    out_window_complete
);
  import eac_pkg::*;

  logic [WIN_W-1:0]  win_r;
  logic [WIN_W-1:0]  nwin;
  logic [WIN_W-1:0]  m_full;
  logic [M_W-1:0]    m;
  logic [LAG_W-1:0]  lag_r;
  logic [WIN_W-1:0]  n_r;
  logic [LAG_W-1:0]  hp_r, t_r, hidx_r, clr_r, td_r, tmax;
  logic [SUM_W-1:0]  sx_r;
  logic [ENV_W-1:0]  e_r;
  logic              wv_r;
  logic              upd;
  logic [2*SAMPLE_BITS-1:0] isq, qsq;
  logic [SQ_W-1:0]   xsq;
  logic              sq_done;
  logic [ENV_W-1:0]  sq_root;
  logic [ENV_W-1:0]  past;
  logic [LAG_W-1:0]  raddr;
  logic              acc_we;
  logic [LAG_W-1:0]  acc_waddr;
  logic [PROD_W-1:0] prod_rd, prod_wd;
  logic [SUM_W-1:0]  dl_rd, dl_wd;
  logic [ENV_W-1:0]  hist_rd;
  logic [M_W+PLO_W-1:0] plo_r;
  logic [M_W+PHI_W-1:0] phi_r;
  logic [OUT_W-1:0]  q_r;
  logic              wc_r;
  logic              out_valid_r;
  logic [LAG_W-1:0]  out_lag_r;
  logic [OUT_W-1:0]  out_cov_r;
  logic              out_wc_r;

  // Window length saturated to its legal range
  always_comb begin
    priority if (win_r < WIN_MIN) nwin = WIN_MIN;
    else if (win_r > WIN_MAX)     nwin = WIN_MAX;
    else                          nwin = win_r;
    m_full = nwin - WIN_W'(MAX_LAG);
    m      = m_full[M_W-1:0];
    tmax   = (n_r >= WIN_W'(MAX_LAG)) ? LAG_TOP : n_r[LAG_W-1:0];
  end

  // Status back to controller
  always_comb begin
    stat.action    = in_action;
    stat.sample_ok = (n_r < nwin);
    stat.sqrt_done = sq_done;
    stat.lag_last  = (t_r == tmax);
    stat.clr_last  = (clr_r == LAG_TOP);
    stat.out_free  = !out_valid_r || !out_stall;
  end

  // Squared magnitude feeds the root unit
  assign isq = (2*SAMPLE_BITS)'(in_in_phase * in_in_phase);
  assign qsq = (2*SAMPLE_BITS)'(in_quadrature * in_quadrature);
  assign xsq = SQ_W'(isq) + SQ_W'(qsq);

  eac_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.sqrt_start),
    .x     (xsq),
    .done  (sq_done),
    .root  (sq_root)
  );

  // Lag sweep: read lag t, write it back in the following cycle
  assign past  = (td_r == '0) ? e_r : hist_rd;
  assign upd   = ((n_r - WIN_W'(td_r)) < WIN_W'(m));
  assign raddr = cmd.lag_run ? t_r : lag_r;
  assign acc_we    = cmd.clr_run || (wv_r && upd);
  assign acc_waddr = cmd.clr_run ? clr_r : td_r;
  assign prod_wd   = cmd.clr_run ? '0 : prod_rd + PROD_W'(past * e_r);
  assign dl_wd     = cmd.clr_run ? '0 : dl_rd + SUM_W'(e_r);

  eac_ram #(.WIDTH(PROD_W), .DEPTH(MAX_LAG + 1)) u_prod (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (prod_wd),
    .raddr (raddr),
    .rdata (prod_rd)
  );

  eac_ram #(.WIDTH(SUM_W), .DEPTH(MAX_LAG + 1)) u_dly (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (dl_wd),
    .raddr (raddr),
    .rdata (dl_rd)
  );

  eac_ram #(.WIDTH(ENV_W), .DEPTH(MAX_LAG)) u_hist (
    .clk   (clk),
    .we    (cmd.finish),
    .waddr (hp_r),
    .wdata (e_r),
    .raddr (hidx_r),
    .rdata (hist_rd)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= WIN_RESET;
      clr_r       <= '0;
      wv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) win_r <= cfg_wr_data;
      if (cmd.clr_run) clr_r <= (clr_r == LAG_TOP) ? '0 : clr_r + LAG_W'(1);
      wv_r <= cmd.lag_run;
      if (cmd.rd_load)     out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Window state and sweep counters
  always_ff @(posedge clk) begin
    td_r <= t_r;
    if (cmd.accept) begin
      lag_r <= (in_read_lag > LAG_TOP) ? LAG_TOP : in_read_lag;
    end
    if (sq_done) e_r <= sq_root;
    if (cmd.sqrt_start) begin
      t_r    <= '0;
      hidx_r <= hp_r;
    end else if (cmd.lag_run) begin
      t_r    <= t_r + LAG_W'(1);
      hidx_r <= (hidx_r == '0) ? HIST_LAST : hidx_r - LAG_W'(1);
    end
    if (cmd.clr_run) begin
      n_r  <= '0;
      hp_r <= '0;
      sx_r <= '0;
    end else if (cmd.finish) begin
      n_r  <= n_r + WIN_W'(1);
      hp_r <= (hp_r == HIST_LAST) ? '0 : hp_r + LAG_W'(1);
      if (n_r < WIN_W'(m)) sx_r <= sx_r + SUM_W'(e_r);
    end
  end

  // Read: split products, then combine
  always_ff @(posedge clk) begin
    if (cmd.rd_mul) begin
      plo_r <= m * prod_rd[PLO_W-1:0];
      phi_r <= m * prod_rd[PROD_W-1:PLO_W];
      q_r   <= OUT_W'(sx_r * dl_rd);
      wc_r  <= (n_r >= nwin);
    end
    if (cmd.rd_load) begin
      out_lag_r <= lag_r;
      out_cov_r <= OUT_W'(plo_r) + (OUT_W'(phi_r) << PLO_W) - q_r;
      out_wc_r  <= wc_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_lag               = out_lag_r;
  assign out_scaled_covariance = out_cov_r;
  assign out_window_complete   = out_wc_r;

endmodule

`default_nettype wire

>>> src/envelope_autocovariance.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake          Beat
// in_       input      in_valid/in_stall  action, in_phase, quadrature, read_lag
// out_      output     out_valid/out_stall lag, scaled_covariance, window_complete
// cfg_      input      cfg_wr_en          window_length
//
// A sample beat is accepted, runs the root unit, sweeps lags 0 to min(n,288)
// (one lag at a time, set by one accumulator memory port) then a history write.
// A read beat runs address, multiply and output steps; ignored beats are dropped.
// After reset and after a restart beat the accumulators are zeroed in a
// pass over all 289 entries with in_stall high. Synchronous active-low reset.
// A waiting result does not block a new input beat until the next read result.

module envelope_autocovariance (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic [1:0]                             in_action,
  input  wire logic signed [eac_pkg::SAMPLE_BITS-1:0] in_in_phase,
  input  wire logic signed [eac_pkg::SAMPLE_BITS-1:0] in_quadrature,
  input  wire logic [eac_pkg::LAG_W-1:0]              in_read_lag,
  input  wire logic                                   cfg_wr_en,
  input  wire logic [eac_pkg::WIN_W-1:0]              cfg_wr_data,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic      [eac_pkg::LAG_W-1:0]              out_lag,
  output logic signed [eac_pkg::OUT_W-1:0]            out_scaled_covariance,
  output logic                                        out_window_complete
);
  import eac_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  eac_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  eac_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .stat                  (stat),
    .in_action             (in_action),
    .in_in_phase           (in_in_phase),
    .in_quadrature         (in_quadrature),
    .in_read_lag           (in_read_lag),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_lag               (out_lag),
    .out_scaled_covariance (out_scaled_covariance),
    .out_window_complete   (out_window_complete)
  );

  // Reset starts the clearing pass, so input is held off
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input not stalled after reset");

  // Sweep, clear and read steps never overlap
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.lag_run, cmd.clr_run, cmd.rd_mul, cmd.rd_load, cmd.finish}))
    else $error("datapath commands overlap");

  // Reported lag is always saturated
  a_lag_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_lag <= LAG_TOP))
    else $error("result lag out of range");

endmodule

`default_nettype wire
